// ----- hdl/apnt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apnt_pkg
// Shared widths, register indexes and status codes of the affine point /
// normal transform unit.
// ----------------------------------------------------------------------------
package apnt_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_ROW_0   = 3'd0;
    localparam logic [2:0] REG_ROW_1   = 3'd1;
    localparam logic [2:0] REG_ROW_2   = 3'd2;
    localparam logic [2:0] REG_TRANS_X = 3'd3;
    localparam logic [2:0] REG_TRANS_Y = 3'd4;
    localparam logic [2:0] REG_TRANS_Z = 3'd5;

    // Reset values of the matrix rows (identity in Q2.14)
    localparam logic [47:0] ROW_0_RST = 48'h0000_0000_4000;
    localparam logic [47:0] ROW_1_RST = 48'h0000_4000_0000;
    localparam logic [47:0] ROW_2_RST = 48'h4000_0000_0000;

    // Vector kinds
    localparam logic KIND_POS    = 1'b0;
    localparam logic KIND_NORMAL = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SAT  = 2'd1;
    localparam logic [1:0] STATUS_NULL = 2'd2;

    // Normalizer datapath widths
    localparam int SQ_W  = 62;          // sum of squares
    localparam int LEN_W = 31;          // vector length (root)
    localparam int Q_W   = 17;          // quotient, at most 2^16
    localparam int NUM_W = LEN_W + 16;  // dividend: magnitude << 16 plus half length

endpackage

// ----- hdl/affine_point_normal_transform_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_point_normal_transform_unit
// Transforms positions by R*p+t and normals by sign(det R)*cof(R), then
// normalizes normals to unit length in Q16.16.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one word per clock while not stalled;
// the pipeline consists of the digit-serial stages of the square root (31)
// and of the normalizing divider (17) plus 13 arithmetic stages.
// Back-pressure on the master side stalls the whole pipeline in place. After
// reset and after every register write the slave side holds tready low while
// the cofactor and determinant registers settle.
// ----------------------------------------------------------------------------
module affine_point_normal_transform_unit (
    input  logic          clk,
    input  logic          rst_n,
    // configuration write port
    input  logic          cfg_we,
    input  logic [2:0]    cfg_addr,
    input  logic [47:0]   cfg_wdata,
    // input words
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [95:0]   s_axis_tdata,   // in_x [31:0], in_y [63:32], in_z [95:64]
    input  logic [0:0]    s_axis_tuser,   // req_type [0]
    // result words
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64],
                                          // status [97:96], zero [103:98]
    output logic [0:0]    m_axis_tuser    // out_kind [0]
);

    localparam logic [2:0] CFG_SETTLE = 3'd4;
    localparam logic signed [36:0] POS_MAX = 37'sd2147483647;
    localparam logic signed [36:0] POS_MIN = -37'sd2147483648;
    localparam int LW = apnt_pkg::LEN_W;

    typedef struct packed {
        logic             kind;
        logic             sat;
        logic             nul;
        logic [2:0]       neg;
        logic [2:0][31:0] pos;
    } tail_t;

    localparam int TL_W = $bits(tail_t);
    localparam int SQ_SIDE_W = TL_W + 3 * LW;

    function automatic logic [5:0] bit_len(input logic [53:0] x);
        logic [5:0] n;
        n = '0;
        for (int b = 0; b < 54; b++)
        begin
            if (x[b])
            begin
                n = 6'(b + 1);
            end
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [47:0]        row_reg   [3];
    logic signed [31:0] trans_reg [3];
    logic [2:0]         settle_reg;
    logic signed [15:0] coef      [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0]   <= apnt_pkg::ROW_0_RST;
            row_reg[1]   <= apnt_pkg::ROW_1_RST;
            row_reg[2]   <= apnt_pkg::ROW_2_RST;
            trans_reg[0] <= '0;
            trans_reg[1] <= '0;
            trans_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                apnt_pkg::REG_ROW_0:   row_reg[0]   <= cfg_wdata;
                apnt_pkg::REG_ROW_1:   row_reg[1]   <= cfg_wdata;
                apnt_pkg::REG_ROW_2:   row_reg[2]   <= cfg_wdata;
                apnt_pkg::REG_TRANS_X: trans_reg[0] <= cfg_wdata[31:0];
                apnt_pkg::REG_TRANS_Y: trans_reg[1] <= cfg_wdata[31:0];
                apnt_pkg::REG_TRANS_Z: trans_reg[2] <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Hold off input until the derived matrix terms are current
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= CFG_SETTLE;
        end
        else if (cfg_we)
        begin
            settle_reg <= CFG_SETTLE;
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - 3'd1;
        end
    end

    // Unpack coefficients
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                coef[i][j] = row_reg[i][16*j +: 16];
            end
        end
    end

    // ------------------------------------------------------------------
    // Cofactors and determinant sign, recomputed every cycle
    // ------------------------------------------------------------------
    logic signed [31:0] cpa_reg  [3][3];
    logic signed [31:0] cpb_reg  [3][3];
    logic signed [32:0] cof_reg  [3][3];
    logic signed [48:0] detp_reg [3];
    logic signed [50:0] det_sum;
    logic               det_neg_reg;
    logic               det_zero_reg;

    assign det_sum = 51'(detp_reg[0]) + 51'(detp_reg[1]) + 51'(detp_reg[2]);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cpa_reg[i][j] <= 32'(coef[(i+1)%3][(j+1)%3]) * 32'(coef[(i+2)%3][(j+2)%3]);
                cpb_reg[i][j] <= 32'(coef[(i+1)%3][(j+2)%3]) * 32'(coef[(i+2)%3][(j+1)%3]);
                cof_reg[i][j] <= 33'(cpa_reg[i][j]) - 33'(cpb_reg[i][j]);
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            detp_reg[j] <= 49'(coef[0][j]) * 49'(cof_reg[0][j]);
        end
        det_neg_reg  <= det_sum < 0;
        det_zero_reg <= det_sum == '0;
    end

    // ------------------------------------------------------------------
    // Handshake: every stage advances together
    // ------------------------------------------------------------------
    logic o_vld_reg;
    logic adv;
    logic s_fire;

    assign adv           = !o_vld_reg || m_axis_tready;
    assign s_axis_tready = adv && (settle_reg == '0);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    logic                a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg;
    logic                f_vld_reg, g_vld_reg, h_vld_reg, i_vld_reg, j_vld_reg;
    logic                k_vld_reg, l_vld_reg;

    logic                a_kind_reg;
    logic signed [31:0]  a_n_reg [3];

    logic                b_kind_reg;
    logic signed [31:0]  b_n_reg [3];
    logic [3:0]          b_sh_reg;
    logic signed [47:0]  b_pp_reg [3][3];

    logic                c_kind_reg;
    logic signed [36:0]  c_pv_reg [3];
    logic signed [20:0]  c_np_reg [3];

    logic                d_kind_reg;
    logic                d_sat_reg;
    logic [2:0][31:0]    d_pos_reg;
    logic signed [53:0]  d_vp_reg [3][3];

    logic                e_kind_reg;
    logic                e_sat_reg;
    logic [2:0][31:0]    e_pos_reg;
    logic signed [54:0]  e_vs_reg [3];

    logic                f_kind_reg;
    logic                f_sat_reg;
    logic                f_dz_reg;
    logic [2:0][31:0]    f_pos_reg;
    logic signed [54:0]  f_v_reg [3];
    logic [53:0]         f_mag_reg [3];

    logic                g_kind_reg;
    logic                g_sat_reg;
    logic                g_nul_reg;
    logic [2:0][31:0]    g_pos_reg;
    logic signed [54:0]  g_v_reg [3];
    logic [53:0]         g_max_reg;

    logic                h_kind_reg;
    logic                h_sat_reg;
    logic                h_nul_reg;
    logic [2:0][31:0]    h_pos_reg;
    logic signed [54:0]  h_v_reg [3];
    logic                h_right_reg;
    logic [4:0]          h_amt_reg;

    tail_t               i_tl_reg;
    logic [2:0][LW-1:0]  i_mg_reg;

    tail_t               j_tl_reg;
    logic [2:0][LW-1:0]  j_mg_reg;
    logic [60:0]         j_sq_reg [3];

    tail_t               k_tl_reg;
    logic [2:0][LW-1:0]  k_mg_reg;
    logic [apnt_pkg::SQ_W-1:0] k_sum_reg;

    tail_t               l_tl_reg;
    logic [2:0][apnt_pkg::NUM_W-1:0] l_num_reg;
    logic [LW-1:0]       l_den_reg;

    logic [1:0]          o_status_reg;
    logic                o_kind_reg;
    logic [2:0][31:0]    o_val_reg;

    // ------------------------------------------------------------------
    // Stage logic
    // ------------------------------------------------------------------
    logic [31:0]         a_mag [3];
    logic [31:0]         a_max;
    logic [5:0]          a_len;
    logic [3:0]          a_sh;
    logic signed [47:0]  a_pp [3][3];

    // Stage A: input magnitude scale and position products
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            a_mag[j] = a_n_reg[j][31] ? 32'(-a_n_reg[j]) : 32'(a_n_reg[j]);
        end
        a_max = a_mag[0];
        if (a_mag[1] > a_max)
        begin
            a_max = a_mag[1];
        end
        if (a_mag[2] > a_max)
        begin
            a_max = a_mag[2];
        end
        a_len = bit_len(54'(a_max));
        a_sh  = (a_len > 6'd20) ? 4'(a_len - 6'd20) : 4'd0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                a_pp[i][j] = 48'(coef[i][j]) * 48'(a_n_reg[j]);
            end
        end
    end

    logic signed [49:0]  b_acc [3];
    logic signed [36:0]  b_pv  [3];
    logic signed [20:0]  b_np  [3];

    // Stage B: round, translate; prescale the normal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_acc[i] = 50'(b_pp_reg[i][0]) + 50'(b_pp_reg[i][1]) + 50'(b_pp_reg[i][2])
                       + 50'sd8192;
            b_pv[i]  = 37'(36'(b_acc[i] >>> 14)) + 37'(trans_reg[i]);
            b_np[i]  = 21'(b_n_reg[i] >>> b_sh_reg);
        end
    end

    logic [2:0][31:0]    c_pos;
    logic                c_sat;
    logic signed [53:0]  c_vp [3][3];

    // Stage C: clamp positions; cofactor products
    always_comb
    begin
        c_sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (c_pv_reg[i] > POS_MAX)
            begin
                c_pos[i] = 32'h7FFF_FFFF;
                c_sat    = 1'b1;
            end
            else if (c_pv_reg[i] < POS_MIN)
            begin
                c_pos[i] = 32'h8000_0000;
                c_sat    = 1'b1;
            end
            else
            begin
                c_pos[i] = c_pv_reg[i][31:0];
            end
            for (int j = 0; j < 3; j++)
            begin
                c_vp[i][j] = 54'(cof_reg[i][j]) * 54'(c_np_reg[j]);
            end
        end
    end

    logic signed [54:0]  d_vs [3];
    logic signed [54:0]  e_v  [3];
    logic [53:0]         e_mag [3];
    logic [53:0]         f_max;
    logic [5:0]          g_len;
    logic [31:0]         h_vn [3];
    logic [2:0]          h_neg;
    logic [2:0][LW-1:0]  h_mg;
    logic [60:0]         i_sq [3];

    // Stages D to I: sum, orient, block-normalize, square
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_vs[i]  = 55'(d_vp_reg[i][0]) + 55'(d_vp_reg[i][1]) + 55'(d_vp_reg[i][2]);
            e_v[i]   = det_neg_reg ? -e_vs_reg[i] : e_vs_reg[i];
            e_mag[i] = e_v[i][54] ? 54'(-e_v[i]) : 54'(e_v[i]);
            h_vn[i]  = h_right_reg ? 32'(h_v_reg[i] >>> h_amt_reg)
                                   : 32'(h_v_reg[i] <<< h_amt_reg);
            h_neg[i] = h_vn[i][31];
            h_mg[i]  = h_neg[i] ? LW'(-h_vn[i]) : LW'(h_vn[i]);
            i_sq[i]  = 61'(i_mg_reg[i]) * 61'(i_mg_reg[i]);
        end
        f_max = f_mag_reg[0];
        if (f_mag_reg[1] > f_max)
        begin
            f_max = f_mag_reg[1];
        end
        if (f_mag_reg[2] > f_max)
        begin
            f_max = f_mag_reg[2];
        end
        g_len = bit_len(g_max_reg);
    end

    // Advance valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            i_vld_reg <= 1'b0;
            j_vld_reg <= 1'b0;
            k_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= s_fire;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
            h_vld_reg <= g_vld_reg;
            i_vld_reg <= h_vld_reg;
            j_vld_reg <= i_vld_reg;
            k_vld_reg <= j_vld_reg;
        end
    end

    // Advance payload of the front stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_kind_reg <= s_axis_tuser[0];
            a_n_reg[0] <= s_axis_tdata[31:0];
            a_n_reg[1] <= s_axis_tdata[63:32];
            a_n_reg[2] <= s_axis_tdata[95:64];

            b_kind_reg <= a_kind_reg;
            b_n_reg    <= a_n_reg;
            b_sh_reg   <= a_sh;
            b_pp_reg   <= a_pp;

            c_kind_reg <= b_kind_reg;
            c_pv_reg   <= b_pv;
            c_np_reg   <= b_np;

            d_kind_reg <= c_kind_reg;
            d_sat_reg  <= c_sat;
            d_pos_reg  <= c_pos;
            d_vp_reg   <= c_vp;

            e_kind_reg <= d_kind_reg;
            e_sat_reg  <= d_sat_reg;
            e_pos_reg  <= d_pos_reg;
            e_vs_reg   <= d_vs;

            f_kind_reg <= e_kind_reg;
            f_sat_reg  <= e_sat_reg;
            f_pos_reg  <= e_pos_reg;
            f_dz_reg   <= det_zero_reg;
            f_v_reg    <= e_v;
            f_mag_reg  <= e_mag;

            g_kind_reg <= f_kind_reg;
            g_sat_reg  <= f_sat_reg;
            g_pos_reg  <= f_pos_reg;
            g_nul_reg  <= f_dz_reg || (f_max == '0);
            g_v_reg    <= f_v_reg;
            g_max_reg  <= f_max;

            h_kind_reg  <= g_kind_reg;
            h_sat_reg   <= g_sat_reg;
            h_pos_reg   <= g_pos_reg;
            h_nul_reg   <= g_nul_reg;
            h_v_reg     <= g_v_reg;
            h_right_reg <= g_len > 6'd30;
            h_amt_reg   <= (g_len > 6'd30) ? 5'(g_len - 6'd30) : 5'(6'd30 - g_len);

            i_tl_reg.kind <= h_kind_reg;
            i_tl_reg.sat  <= h_sat_reg;
            i_tl_reg.nul  <= h_nul_reg;
            i_tl_reg.neg  <= h_neg;
            i_tl_reg.pos  <= h_pos_reg;
            i_mg_reg      <= h_mg;

            j_tl_reg <= i_tl_reg;
            j_mg_reg <= i_mg_reg;
            j_sq_reg <= i_sq;

            k_tl_reg  <= j_tl_reg;
            k_mg_reg  <= j_mg_reg;
            k_sum_reg <= apnt_pkg::SQ_W'(j_sq_reg[0]) + apnt_pkg::SQ_W'(j_sq_reg[1])
                         + apnt_pkg::SQ_W'(j_sq_reg[2]);
        end
    end

    // ------------------------------------------------------------------
    // Vector length
    // ------------------------------------------------------------------
    logic                 q_vld;
    logic [LW-1:0]        q_root;
    logic [SQ_SIDE_W-1:0] q_side;
    tail_t                q_tl;
    logic [2:0][LW-1:0]   q_mg;

    apnt_sqrt_pipe #(
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (k_vld_reg),
        .in_rad   (k_sum_reg),
        .in_side  ({k_tl_reg, k_mg_reg}),
        .out_vld  (q_vld),
        .out_root (q_root),
        .out_side (q_side)
    );

    assign {q_tl, q_mg} = q_side;

    // Stage L: build rounded dividends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            l_vld_reg <= q_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_tl_reg  <= q_tl;
            l_den_reg <= q_root;
            for (int i = 0; i < 3; i++)
            begin
                l_num_reg[i] <= (apnt_pkg::NUM_W'(q_mg[i]) << 16)
                                + apnt_pkg::NUM_W'(q_root >> 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Normalizing divide
    // ------------------------------------------------------------------
    logic                           dv_vld;
    logic [2:0][apnt_pkg::Q_W-1:0]  dv_quo;
    logic [TL_W-1:0]                dv_side;
    tail_t                          dv_tl;

    apnt_div_pipe #(
        .SIDE_W (TL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (l_vld_reg),
        .in_num   (l_num_reg),
        .in_den   (l_den_reg),
        .in_side  (l_tl_reg),
        .out_vld  (dv_vld),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    assign dv_tl = dv_side;

    // ------------------------------------------------------------------
    // Output register: select position or signed unit normal
    // ------------------------------------------------------------------
    logic [2:0][31:0] o_val;
    logic [1:0]       o_status;

    always_comb
    begin
        logic [31:0] qv;
        for (int i = 0; i < 3; i++)
        begin
            qv = 32'(dv_quo[i]);
            if (dv_tl.kind == apnt_pkg::KIND_POS)
            begin
                o_val[i] = dv_tl.pos[i];
            end
            else if (dv_tl.nul)
            begin
                o_val[i] = '0;
            end
            else
            begin
                o_val[i] = dv_tl.neg[i] ? -qv : qv;
            end
        end
        if (dv_tl.kind == apnt_pkg::KIND_POS)
        begin
            o_status = dv_tl.sat ? apnt_pkg::STATUS_SAT : apnt_pkg::STATUS_OK;
        end
        else
        begin
            o_status = dv_tl.nul ? apnt_pkg::STATUS_NULL : apnt_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            o_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_kind_reg   <= dv_tl.kind;
            o_val_reg    <= o_val;
            o_status_reg <= o_status;
        end
    end

    assign m_axis_tvalid = o_vld_reg;
    assign m_axis_tdata  = {6'b0, o_status_reg, o_val_reg[2], o_val_reg[1], o_val_reg[0]};
    assign m_axis_tuser  = o_kind_reg;

endmodule

// ----- hdl/apnt_sqrt_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apnt_sqrt_pipe
// Pipelined integer square root, one result bit per stage, floor result.
// A side word travels along with each radicand.
// ----------------------------------------------------------------------------
module apnt_sqrt_pipe #(
    parameter int SIDE_W = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [apnt_pkg::SQ_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_vld,
    output logic [apnt_pkg::LEN_W-1:0] out_root,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int N  = apnt_pkg::LEN_W;
    localparam int XW = apnt_pkg::SQ_W;
    localparam int RW = XW + 1;

    logic [XW-1:0]     x_reg    [N];
    logic [RW-1:0]     res_reg  [N];
    logic [SIDE_W-1:0] side_reg [N];
    logic [N-1:0]      vld_reg;
    logic [XW-1:0]     x_next   [N];
    logic [RW-1:0]     res_next [N];

    // One digit step per stage: try to subtract the running root plus the bit
    always_comb
    begin
        logic [XW-1:0] xi;
        logic [RW-1:0] ri;
        logic [RW-1:0] bitv;
        logic [RW-1:0] trial;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                xi = in_rad;
                ri = '0;
            end
            else
            begin
                xi = x_reg[k-1];
                ri = res_reg[k-1];
            end
            bitv  = RW'(1) << (2 * (N - 1 - k));
            trial = ri + bitv;
            if ({1'b0, xi} >= trial)
            begin
                x_next[k]   = xi - trial[XW-1:0];
                res_next[k] = (ri >> 1) + bitv;
            end
            else
            begin
                x_next[k]   = xi;
                res_next[k] = ri >> 1;
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_vld};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                x_reg[k]   <= x_next[k];
                res_reg[k] <= res_next[k];
                if (k == 0)
                begin
                    side_reg[k] <= in_side;
                end
                else
                begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_root = res_reg[N-1][N-1:0];
    assign out_side = side_reg[N-1];

endmodule

// ----- hdl/apnt_div_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apnt_div_pipe
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage. The quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module apnt_div_pipe #(
    parameter int SIDE_W = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  logic [2:0][apnt_pkg::NUM_W-1:0]      in_num,
    input  logic [apnt_pkg::LEN_W-1:0]           in_den,
    input  logic [SIDE_W-1:0]                    in_side,
    output logic                                 out_vld,
    output logic [2:0][apnt_pkg::Q_W-1:0]        out_quo,
    output logic [SIDE_W-1:0]                    out_side
);

    localparam int N  = apnt_pkg::Q_W;
    localparam int DW = apnt_pkg::LEN_W;
    localparam int NW = apnt_pkg::NUM_W;

    logic [2:0][DW-1:0] rem_reg  [N];
    logic [2:0][N-1:0]  low_reg  [N];
    logic [2:0][N-1:0]  quo_reg  [N];
    logic [DW-1:0]      den_reg  [N];
    logic [SIDE_W-1:0]  side_reg [N];
    logic [N-1:0]       vld_reg;
    logic [2:0][DW-1:0] rem_next [N];
    logic [2:0][N-1:0]  low_next [N];
    logic [2:0][N-1:0]  quo_next [N];
    logic [DW-1:0]      den_next [N];

    // Shift in one dividend bit per stage and subtract the divisor if it fits
    always_comb
    begin
        logic [DW-1:0] ri;
        logic [N-1:0]  lo;
        logic [N-1:0]  qi;
        logic [DW-1:0] di;
        logic [DW:0]   t;
        logic          ge;
        for (int k = 0; k < N; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (k == 0)
                begin
                    ri = DW'(in_num[l][NW-1:N]);
                    lo = in_num[l][N-1:0];
                    qi = '0;
                    di = in_den;
                end
                else
                begin
                    ri = rem_reg[k-1][l];
                    lo = low_reg[k-1][l];
                    qi = quo_reg[k-1][l];
                    di = den_reg[k-1];
                end
                t  = {ri, lo[N-1]};
                ge = (t >= {1'b0, di});
                if (ge)
                begin
                    rem_next[k][l] = DW'(t - {1'b0, di});
                end
                else
                begin
                    rem_next[k][l] = t[DW-1:0];
                end
                low_next[k][l] = lo << 1;
                quo_next[k][l] = {qi[N-2:0], ge};
                den_next[k]    = di;
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_vld};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_next[k];
                if (k == 0)
                begin
                    side_reg[k] <= in_side;
                end
                else
                begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_quo  = quo_reg[N-1];
    assign out_side = side_reg[N-1];

endmodule

// ----- verif/affine_point_normal_transform_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_point_normal_transform_unit_tb
// Drives positions and normals through the transform unit under several
// matrix and translation settings. A behavioral model in the bench predicts
// each result word and a checker compares kind, coordinates and status in order.
// ----------------------------------------------------------------------------
module affine_point_normal_transform_unit_tb;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 80;

    typedef struct packed {
        logic        kind;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [1:0]  status;
    } vec_result_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [2:0]    cfg_addr;
    logic [47:0]   cfg_wdata;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [95:0]   s_axis_tdata;
    logic [0:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [103:0]  m_axis_tdata;
    logic [0:0]    m_axis_tuser;

    // shadow copy of the register file
    logic [47:0] mat_row [3];
    logic [31:0] trans [3];

    vec_result_t expected_vecs [$];
    int          error_count;
    int          result_count;
    int          normal_count;
    int          sat_count;
    int          null_count;
    int          idle_cycles;
    bit          idle_enable;

    affine_point_normal_transform_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // floor division by 2^s for signed values
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint coef(int r, int c);
        return longint'($signed(mat_row[r][16*c +: 16]));
    endfunction

    function automatic longint root64(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic vec_result_t transform_vec(logic kind, logic [31:0] ix,
                                                  logic [31:0] iy, logic [31:0] iz);
        vec_result_t     r;
        longint          nv [3];
        longint          cf [3][3];
        longint          vv [3];
        longint          det;
        longint          acc;
        longint          sum;
        longint unsigned mx;
        longint unsigned sq;
        longint unsigned len;
        longint unsigned q;
        longint unsigned mg;
        int              s;
        int              rs;
        int              ls;
        bit              sat;
        r.kind = kind;
        r.status = apnt_pkg::STATUS_OK;
        nv[0] = longint'($signed(ix));
        nv[1] = longint'($signed(iy));
        nv[2] = longint'($signed(iz));
        if (kind == apnt_pkg::KIND_POS)
        begin
            sat = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                acc = coef(i, 0) * nv[0] + coef(i, 1) * nv[1] + coef(i, 2) * nv[2];
                sum = floor_shift(acc + 8192, 14) + longint'($signed(trans[i]));
                if (sum > 64'sd2147483647)
                begin
                    sum = 64'sd2147483647;
                    sat = 1'b1;
                end
                else if (sum < -64'sd2147483648)
                begin
                    sum = -64'sd2147483648;
                    sat = 1'b1;
                end
                vv[i] = sum;
            end
            if (sat)
                r.status = apnt_pkg::STATUS_SAT;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    cf[j][i] = coef((i + 1) % 3, (j + 1) % 3) * coef((i + 2) % 3, (j + 2) % 3)
                             - coef((i + 1) % 3, (j + 2) % 3) * coef((i + 2) % 3, (j + 1) % 3);
            // cf[j][i] above is cofactor C(i,j); transpose back
            det = coef(0, 0) * cf[0][0] + coef(0, 1) * cf[1][0] + coef(0, 2) * cf[2][0];
            mx = 0;
            for (int i = 0; i < 3; i++)
            begin
                mg = (nv[i] < 0) ? longint'(-nv[i]) : nv[i];
                if (mg > mx)
                    mx = mg;
            end
            s = 0;
            while ((mx >> s) >= (64'd1 << 20))
                s++;
            for (int i = 0; i < 3; i++)
                nv[i] = floor_shift(nv[i], s);
            mx = 0;
            for (int i = 0; i < 3; i++)
            begin
                vv[i] = cf[0][i] * nv[0] + cf[1][i] * nv[1] + cf[2][i] * nv[2];
                if (det < 0)
                    vv[i] = -vv[i];
                mg = (vv[i] < 0) ? longint'(-vv[i]) : vv[i];
                if (mg > mx)
                    mx = mg;
            end
            if (det == 0 || mx == 0)
            begin
                vv[0] = 0;
                vv[1] = 0;
                vv[2] = 0;
                r.status = apnt_pkg::STATUS_NULL;
            end
            else
            begin
                rs = 0;
                ls = 0;
                while ((mx >> rs) >= (64'd1 << 30))
                    rs++;
                while ((mx << ls) < (64'd1 << 29))
                    ls++;
                sq = 0;
                for (int i = 0; i < 3; i++)
                begin
                    if (rs > 0)
                        vv[i] = floor_shift(vv[i], rs);
                    else
                        vv[i] = vv[i] <<< ls;
                    mg = (vv[i] < 0) ? longint'(-vv[i]) : vv[i];
                    sq += mg * mg;
                end
                len = root64(sq);
                for (int i = 0; i < 3; i++)
                begin
                    mg = (vv[i] < 0) ? longint'(-vv[i]) : vv[i];
                    q = ((mg << 16) + (len >> 1)) / len;
                    vv[i] = (vv[i] < 0) ? -longint'(q) : longint'(q);
                end
            end
        end
        r.x = vv[0][31:0];
        r.y = vv[1][31:0];
        r.z = vv[2][31:0];
        return r;
    endfunction

    // write one register while the block is idle
    task automatic write_reg(logic [2:0] idx, logic [47:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx <= apnt_pkg::REG_ROW_2)
            mat_row[idx[1:0]] = value;
        else
            trans[2'(idx - apnt_pkg::REG_TRANS_X)] = value[31:0];
    endtask

    task automatic load_setting(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
                                logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
        write_reg(apnt_pkg::REG_ROW_0, r0);
        write_reg(apnt_pkg::REG_ROW_1, r1);
        write_reg(apnt_pkg::REG_ROW_2, r2);
        write_reg(apnt_pkg::REG_TRANS_X, {16'd0, tx});
        write_reg(apnt_pkg::REG_TRANS_Y, {16'd0, ty});
        write_reg(apnt_pkg::REG_TRANS_Z, {16'd0, tz});
    endtask

    // send one word; valid stays high across back-to-back words
    task automatic send_vec(logic kind, logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
        int gap;
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {iz, iy, ix};
        expected_vecs = {expected_vecs, transform_vec(kind, ix, iy, iz)};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // drop valid right after the last accepted word, then wait for all results
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_vecs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0003_ffff) - 32'h0001_ffff;
            2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
            default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return 16'($urandom());
            1: return 16'($urandom_range(0, 32'h8000)) - 16'h4000;
            2: return 16'h0000;
            default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    task automatic test_identity_directed();
        send_vec(apnt_pkg::KIND_POS, 32'h0001_0000, 32'hffff_0000, 32'h0000_0000);
        send_vec(apnt_pkg::KIND_POS, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        send_vec(apnt_pkg::KIND_NORMAL, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
        send_vec(apnt_pkg::KIND_NORMAL, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        // zero-length normal
        send_vec(apnt_pkg::KIND_NORMAL, 32'h0, 32'h0, 32'h0);
        send_vec(apnt_pkg::KIND_NORMAL, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0003);
        wait_drained();
    endtask

    task automatic test_extreme_directed();
        // full-scale matrix and translation: positions saturate both ways
        load_setting({3{16'h7fff}}, {16'h8000, 16'h7fff, 16'h8000}, {16'h0001, 16'h8000, 16'h7fff},
                     32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        send_vec(apnt_pkg::KIND_POS, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vec(apnt_pkg::KIND_POS, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vec(apnt_pkg::KIND_POS, 32'h0, 32'h0, 32'h0);
        send_vec(apnt_pkg::KIND_NORMAL, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678);
        send_vec(apnt_pkg::KIND_NORMAL, 32'h0000_0010, 32'h0, 32'hffff_fff0);
        wait_drained();
        // singular matrix
        load_setting({16'h0, 16'h4000, 16'h2000}, {16'h0, 16'h8000, 16'hc000}, 48'h0,
                     32'h0, 32'h0, 32'h0);
        send_vec(apnt_pkg::KIND_NORMAL, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_vec(apnt_pkg::KIND_POS, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        wait_drained();
        // mirror: negative determinant
        load_setting({16'h0, 16'h0, 16'hc000}, {16'h0, 16'h4000, 16'h0},
                     {16'h4000, 16'h0, 16'h0}, 32'hffff_8000, 32'h0, 32'h0000_8000);
        send_vec(apnt_pkg::KIND_NORMAL, 32'h0001_0000, 32'h0, 32'h0);
        send_vec(apnt_pkg::KIND_NORMAL, 32'h0, 32'h0, 32'hffff_0000);
        send_vec(apnt_pkg::KIND_POS, 32'h0000_2000, 32'hffff_e000, 32'h0000_0001);
        wait_drained();
    endtask

    task automatic test_random_phase(int count);
        for (int k = 0; k < count; k++)
            send_vec(logic'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord());
        wait_drained();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 6; ph++)
        begin
            load_setting({rand_coef(), rand_coef(), rand_coef()},
                         {rand_coef(), rand_coef(), rand_coef()},
                         {rand_coef(), rand_coef(), rand_coef()},
                         rand_coord(), rand_coord(), rand_coord());
            test_random_phase(200);
        end
        // back to identity, no idling on either side
        load_setting(apnt_pkg::ROW_0_RST, apnt_pkg::ROW_1_RST, apnt_pkg::ROW_2_RST,
                     32'h0, 32'h0, 32'h0);
        idle_enable = 1'b0;
        test_random_phase(230);
    endtask

    // receiver stalls in random bursts
    always @(posedge clk)
    begin
        if (idle_cycles > 0)
        begin
            idle_cycles   <= idle_cycles - 1;
            m_axis_tready <= (idle_cycles == 1);
        end
        else if (idle_enable && rst_n && $urandom_range(0, 7) == 0)
        begin
            idle_cycles   <= $urandom_range(1, 9);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        vec_result_t got;
        vec_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[63:32],
                   m_axis_tdata[95:64], m_axis_tdata[97:96]};
            if (expected_vecs.size() == 0)
            begin
                $error("result word with no prediction pending");
                error_count++;
            end
            else
            begin
                want = expected_vecs.pop_front();
                result_count++;
                if (want.kind == apnt_pkg::KIND_NORMAL)
                    normal_count++;
                if (want.status == apnt_pkg::STATUS_SAT)
                    sat_count++;
                if (want.status == apnt_pkg::STATUS_NULL)
                    null_count++;
                if (got.kind !== want.kind)
                begin
                    $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
                    error_count++;
                end
                if (got.x !== want.x)
                begin
                    $error("out_x: expected %h, got %h", want.x, got.x);
                    error_count++;
                end
                if (got.y !== want.y)
                begin
                    $error("out_y: expected %h, got %h", want.y, got.y);
                    error_count++;
                end
                if (got.z !== want.z)
                begin
                    $error("out_z: expected %h, got %h", want.z, got.z);
                    error_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    // end the run when no word moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_CYCLES)
            begin
                $display("watchdog expired with %0d results pending", expected_vecs.size());
                $display("** affine_point_normal_transform_unit: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        error_count   = 0;
        result_count  = 0;
        normal_count  = 0;
        sat_count     = 0;
        null_count    = 0;
        idle_cycles   = 0;
        idle_enable   = 1'b1;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = apnt_pkg::REG_ROW_0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = apnt_pkg::KIND_POS;
        m_axis_tready = 1'b1;
        mat_row[0] = apnt_pkg::ROW_0_RST;
        mat_row[1] = apnt_pkg::ROW_1_RST;
        mat_row[2] = apnt_pkg::ROW_2_RST;
        trans[0] = '0;
        trans[1] = '0;
        trans[2] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_identity_directed();
        test_extreme_directed();
        test_random_settings();

        $display("checked %0d words: %0d normals, %0d saturated, %0d null, over 11 settings",
                 result_count, normal_count, sat_count, null_count);
        if (error_count == 0)
            $display("** affine_point_normal_transform_unit: PASSED **");
        else
            $display("** affine_point_normal_transform_unit: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/apnt_pkg.sv
hdl/apnt_sqrt_pipe.sv
hdl/apnt_div_pipe.sv
hdl/affine_point_normal_transform_unit.sv
verif/affine_point_normal_transform_unit_tb.sv
